// File: rtl/core/csvt_pkg.sv
// ----------------------------------------------------------------------------
// csvt_pkg
// Shared types and constants of the CSV field tokenizer.
// ----------------------------------------------------------------------------
package csvt_pkg;

  localparam int unsigned MAX_COLUMNS = 1024;
  localparam int unsigned COL_W = 10;
  localparam logic [COL_W-1:0] COL_TOP =
      (MAX_COLUMNS - 1 < 1023) ? COL_W'(MAX_COLUMNS - 1) : COL_W'(1023);

  localparam logic [7:0] CHAR_COMMA = 8'd44;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;

  localparam logic [15:0] HDR_SEEN_MAX = 16'hFFFF;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DELIMITER = 2'd0;
  localparam logic [1:0] CFG_TRIM = 2'd1;
  localparam logic [1:0] CFG_HDR_SKIP = 2'd2;

  typedef enum logic [5:0] {
    MODE_HDR_OUT = 6'b000001,
    MODE_HDR_INQ = 6'b000010,
    MODE_HDR_QP  = 6'b000100,
    MODE_DAT_OUT = 6'b001000,
    MODE_DAT_INQ = 6'b010000,
    MODE_DAT_QP  = 6'b100000
  } mode_e;

  typedef struct packed {
    logic [7:0]  delimiter;
    logic        trim;
    logic [15:0] hdr_skip;
  } cfg_t;

  typedef struct packed {
    mode_e            mode;
    logic [15:0]      hdr_seen;
    logic             field_has;
    logic             row_has;
    logic [COL_W-1:0] col;
  } state_t;

  typedef struct packed {
    logic             char_valid;
    logic [7:0]       char_out;
    logic [COL_W-1:0] column_index;
    logic             field_done;
    logic             row_done;
    logic             input_done;
    logic             row_dropped;
    logic             quote_error;
  } result_t;

endpackage

// File: rtl/core/csvt_if.sv
// ----------------------------------------------------------------------------
// csvt_in_if / csvt_out_if
// Valid/ready channels for text bytes in and tokens out.
// ----------------------------------------------------------------------------
interface csvt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface csvt_out_if;
  logic                     valid;
  logic                     ready;
  logic                     char_valid;
  logic [7:0]               char_out;
  logic [csvt_pkg::COL_W-1:0] column_index;
  logic                     field_done;
  logic                     row_done;
  logic                     input_done;
  logic                     row_dropped;
  logic                     quote_error;

  modport source (output valid, output char_valid, output char_out, output column_index,
                  output field_done, output row_done, output input_done,
                  output row_dropped, output quote_error, input ready);
  modport sink (input valid, input char_valid, input char_out, input column_index,
                input field_done, input row_done, input input_done,
                input row_dropped, input quote_error, output ready);
endinterface

// File: rtl/core/csvt_step.sv
// ----------------------------------------------------------------------------
// csvt_step
// Parser step: next state and optional token for one byte or end of input.
// ----------------------------------------------------------------------------
module csvt_step (
  input  csvt_pkg::cfg_t    cfg_i,
  input  csvt_pkg::state_t  cur_i,
  input  logic [7:0]        in_byte_i,
  input  logic              end_of_input_i,
  output csvt_pkg::state_t  nxt_o,
  output csvt_pkg::result_t res_o,
  output logic              res_valid_o
);

  logic go_hdr;
  logic go_dat;
  logic is_quote;
  logic is_blank;

  assign is_quote = (in_byte_i == csvt_pkg::CHAR_QUOTE);
  assign is_blank = (in_byte_i == csvt_pkg::CHAR_SPACE) || (in_byte_i == csvt_pkg::CHAR_TAB);

  always_comb begin
    nxt_o = cur_i;
    res_o = '0;
    res_valid_o = 1'b0;
    go_hdr = 1'b0;
    go_dat = 1'b0;

    if (end_of_input_i) begin
      res_valid_o = 1'b1;
      res_o.input_done = 1'b1;
      res_o.row_dropped = (cur_i.mode == csvt_pkg::MODE_DAT_OUT ||
                           cur_i.mode == csvt_pkg::MODE_DAT_INQ ||
                           cur_i.mode == csvt_pkg::MODE_DAT_QP) &&
                          (cur_i.row_has || cur_i.field_has);
      res_o.quote_error = (cur_i.mode == csvt_pkg::MODE_HDR_INQ) ||
                          (cur_i.mode == csvt_pkg::MODE_DAT_INQ);
      nxt_o.mode = csvt_pkg::MODE_HDR_OUT;
      nxt_o.hdr_seen = '0;
      nxt_o.field_has = 1'b0;
      nxt_o.row_has = 1'b0;
      nxt_o.col = '0;
    end else begin
      unique case (cur_i.mode)
        csvt_pkg::MODE_HDR_OUT: go_hdr = 1'b1;
        csvt_pkg::MODE_HDR_INQ: begin
          if (is_quote) nxt_o.mode = csvt_pkg::MODE_HDR_QP;
        end
        csvt_pkg::MODE_HDR_QP: begin
          if (is_quote) nxt_o.mode = csvt_pkg::MODE_HDR_INQ;
          else go_hdr = 1'b1;
        end
        csvt_pkg::MODE_DAT_INQ: begin
          if (is_quote) begin
            nxt_o.mode = csvt_pkg::MODE_DAT_QP;
          end else begin
            res_valid_o = 1'b1;
            res_o.char_valid = 1'b1;
            res_o.char_out = in_byte_i;
            res_o.column_index = cur_i.col;
          end
        end
        csvt_pkg::MODE_DAT_QP: begin
          if (is_quote) begin
            // Doubled quote: a literal quote inside the quoted field.
            nxt_o.mode = csvt_pkg::MODE_DAT_INQ;
            res_valid_o = 1'b1;
            res_o.char_valid = 1'b1;
            res_o.char_out = in_byte_i;
            res_o.column_index = cur_i.col;
          end else begin
            go_dat = 1'b1;
          end
        end
        default: go_dat = 1'b1;
      endcase

      if (go_hdr) begin
        if (cur_i.hdr_seen >= cfg_i.hdr_skip) begin
          go_dat = 1'b1;
        end else begin
          nxt_o.mode = csvt_pkg::MODE_HDR_OUT;
          if (is_quote) begin
            nxt_o.mode = csvt_pkg::MODE_HDR_INQ;
          end else if (in_byte_i == csvt_pkg::CHAR_LF &&
                       cur_i.hdr_seen != csvt_pkg::HDR_SEEN_MAX) begin
            nxt_o.hdr_seen = cur_i.hdr_seen + 16'd1;
          end
        end
      end

      if (go_dat) begin
        nxt_o.mode = csvt_pkg::MODE_DAT_OUT;
        if (is_quote) begin
          nxt_o.mode = csvt_pkg::MODE_DAT_INQ;
          nxt_o.field_has = 1'b1;
          nxt_o.row_has = 1'b1;
        end else if (in_byte_i == csvt_pkg::CHAR_CR) begin
          nxt_o.mode = csvt_pkg::MODE_DAT_OUT;
        end else if (in_byte_i == csvt_pkg::CHAR_LF) begin
          // An empty line gives no token at all.
          if (cur_i.row_has || cur_i.field_has) begin
            res_valid_o = 1'b1;
            res_o.column_index = cur_i.col;
            res_o.field_done = 1'b1;
            res_o.row_done = 1'b1;
            nxt_o.col = '0;
            nxt_o.field_has = 1'b0;
            nxt_o.row_has = 1'b0;
          end
        end else if (in_byte_i == cfg_i.delimiter) begin
          res_valid_o = 1'b1;
          res_o.column_index = cur_i.col;
          res_o.field_done = 1'b1;
          if (cur_i.col < csvt_pkg::COL_TOP) nxt_o.col = cur_i.col + 1'b1;
          nxt_o.field_has = 1'b0;
          nxt_o.row_has = 1'b1;
        end else if (!(cfg_i.trim && !cur_i.field_has && is_blank)) begin
          nxt_o.field_has = 1'b1;
          nxt_o.row_has = 1'b1;
          res_valid_o = 1'b1;
          res_o.char_valid = 1'b1;
          res_o.char_out = in_byte_i;
          res_o.column_index = cur_i.col;
        end
      end
    end
  end

endmodule

// File: rtl/core/csvt_out_stage.sv
// ----------------------------------------------------------------------------
// csvt_out_stage
// Result register that drives the token channel and holds it under stall.
// ----------------------------------------------------------------------------
module csvt_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  csvt_pkg::result_t res_i,
  output logic              room_o,
  csvt_out_if.source        out_o
);

  logic              valid_q;
  csvt_pkg::result_t res_q;

  assign room_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (room_o) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (room_o && push_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid = valid_q;
  assign out_o.char_valid = res_q.char_valid;
  assign out_o.char_out = res_q.char_out;
  assign out_o.column_index = res_q.column_index;
  assign out_o.field_done = res_q.field_done;
  assign out_o.row_done = res_q.row_done;
  assign out_o.input_done = res_q.input_done;
  assign out_o.row_dropped = res_q.row_dropped;
  assign out_o.quote_error = res_q.quote_error;

endmodule

// File: rtl/core/csv_field_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// csv_field_tokenizer_unit
// Streaming CSV tokenizer: text bytes in, field characters and field/row
// end marks out.
// ----------------------------------------------------------------------------
//
//   channel   direction  carries
//   in_i      sink       in_byte, end_of_input
//   res_o     source     char_valid, char_out, column_index, field_done,
//                        row_done, input_done, row_dropped, quote_error
//   cfg_*     write      delimiter, trim flag, header line count
//
// Each item passes from the input register through the parser step into the
// result register, which holds its token. A new item can be accepted in every
// cycle unless an item that makes a token is held by a full, stalled result
// register; the rate is one item per cycle.
// Reset clears the parser state and loads the default configuration.
// While a token waits in the result register, the input register still takes
// one item; an item that makes no token moves on even when the output stalls.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  csvt_in_if.sink     in_i,
  csvt_out_if.source  res_o
);

  // Configuration registers.
  csvt_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delimiter <= csvt_pkg::CHAR_COMMA;
      cfg_q.trim <= 1'b1;
      cfg_q.hdr_skip <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        csvt_pkg::CFG_DELIMITER: cfg_q.delimiter <= cfg_data_i[7:0];
        csvt_pkg::CFG_TRIM:      cfg_q.trim <= cfg_data_i[0];
        csvt_pkg::CFG_HDR_SKIP:  cfg_q.hdr_skip <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register. It frees up whenever its item can be retired into the
  // parser, which is the case unless the item makes a token and the result
  // register is full and stalled.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       eoi_q;
  logic       advance;
  logic       room;

  csvt_pkg::state_t  st_q;
  csvt_pkg::state_t  st_d;
  csvt_pkg::result_t res_d;
  logic              res_valid_d;

  assign advance = in_valid_q && (room || !res_valid_d);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.in_byte;
      eoi_q <= in_i.end_of_input;
    end
  end

  // Parser step between the input register and the result register.
  csvt_step u_step (
    .cfg_i          (cfg_q),
    .cur_i          (st_q),
    .in_byte_i      (in_byte_q),
    .end_of_input_i (eoi_q),
    .nxt_o          (st_d),
    .res_o          (res_d),
    .res_valid_o    (res_valid_d)
  );

  // Parser state only moves when an item is retired.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode <= csvt_pkg::MODE_HDR_OUT;
      st_q.hdr_seen <= '0;
      st_q.field_has <= 1'b0;
      st_q.row_has <= 1'b0;
      st_q.col <= '0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  csvt_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (advance && res_valid_d),
    .res_i  (res_d),
    .room_o (room),
    .out_o  (res_o)
  );

`ifndef NO_ASSERTIONS
  // End of input always returns the parser to its starting point.
  a_eoi_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
      advance && eoi_q |=> st_q.mode == csvt_pkg::MODE_HDR_OUT && st_q.col == '0 &&
                           !st_q.row_has && !st_q.field_has)
    else $error("parser state not cleared after end of input");

  // The column counter saturates and never runs past its top value.
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      st_q.col <= csvt_pkg::COL_TOP)
    else $error("column counter beyond its top value");

  // Error and drop flags only ride on the end-of-input token.
  a_flags_on_eoi: assert property (@(posedge clk_i) disable iff (!rst_ni)
      res_o.valid && (res_o.quote_error || res_o.row_dropped) |-> res_o.input_done)
    else $error("end-of-input flag on an ordinary token");

  // A held item in the input register is neither lost nor overwritten.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_valid_q && !advance |=> in_valid_q && $stable(in_byte_q) && $stable(eoi_q))
    else $error("stalled input item overwritten");
`endif

endmodule

// File: tb/tb_csv_field_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// tb_csv_field_tokenizer_unit
// Self-checking bench for the CSV tokenizer. It streams short directed text
// and random CSV files with quotes, escapes, blanks and early ends of input
// under several register settings, and checks every token against its own
// model of the parser.
// ----------------------------------------------------------------------------
module tb_csv_field_tokenizer_unit;
  import csvt_pkg::*;

  // Tracks the parser state and the register values, computes the token that
  // each accepted byte causes, and matches the tokens that come out.
  class token_scoreboard;
    logic [7:0]       delimiter;
    logic             trim;
    logic [15:0]      hdr_skip;
    mode_e            mode;
    logic [15:0]      hdr_seen;
    logic             field_has;
    logic             row_has;
    logic [COL_W-1:0] col;
    result_t          token;
    result_t          expected_tokens[$];
    int unsigned      failures;

    function new();
      delimiter = CHAR_COMMA;
      trim      = 1'b1;
      hdr_skip  = '0;
      failures  = 0;
      clear_parser();
    endfunction

    function void clear_parser();
      mode      = MODE_HDR_OUT;
      hdr_seen  = '0;
      field_has = 1'b0;
      row_has   = 1'b0;
      col       = '0;
    endfunction

    function void load_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        CFG_DELIMITER: delimiter = data[7:0];
        CFG_TRIM:      trim = data[0];
        CFG_HDR_SKIP:  hdr_skip = data;
        default: ;
      endcase
    endfunction

    function bit emit_char(logic [7:0] c);
      token.char_valid   = 1'b1;
      token.char_out     = c;
      token.column_index = col;
      return 1'b1;
    endfunction

    // Outside quotes: quote first, then CR, LF, delimiter and trimming.
    function bit data_outside(logic [7:0] c);
      mode = MODE_DAT_OUT;
      if (c == CHAR_QUOTE) begin
        mode      = MODE_DAT_INQ;
        field_has = 1'b1;
        row_has   = 1'b1;
        return 1'b0;
      end
      if (c == CHAR_CR) return 1'b0;
      if (c == CHAR_LF) begin
        // An empty line makes no token.
        if (!row_has && !field_has) return 1'b0;
        token.column_index = col;
        token.field_done   = 1'b1;
        token.row_done     = 1'b1;
        col       = '0;
        field_has = 1'b0;
        row_has   = 1'b0;
        return 1'b1;
      end
      if (c == delimiter) begin
        token.column_index = col;
        token.field_done   = 1'b1;
        if (col < COL_TOP) col = col + 1'b1;
        field_has = 1'b0;
        row_has   = 1'b1;
        return 1'b1;
      end
      if (trim && !field_has && (c == CHAR_SPACE || c == CHAR_TAB)) return 1'b0;
      field_has = 1'b1;
      row_has   = 1'b1;
      return emit_char(c);
    endfunction

    function bit header_outside(logic [7:0] c);
      mode = MODE_HDR_OUT;
      if (hdr_seen >= hdr_skip) return data_outside(c);
      if (c == CHAR_QUOTE) mode = MODE_HDR_INQ;
      else if (c == CHAR_LF && hdr_seen < HDR_SEEN_MAX) hdr_seen = hdr_seen + 1'b1;
      return 1'b0;
    endfunction

    function bit tokenize_byte(logic [7:0] c, logic eoi);
      token = '0;
      if (eoi) begin
        token.input_done  = 1'b1;
        token.row_dropped = (mode inside {MODE_DAT_OUT, MODE_DAT_INQ, MODE_DAT_QP}) &&
                            (row_has || field_has);
        token.quote_error = (mode == MODE_HDR_INQ) || (mode == MODE_DAT_INQ);
        clear_parser();
        return 1'b1;
      end
      case (mode)
        MODE_HDR_OUT: return header_outside(c);
        MODE_HDR_INQ: begin
          if (c == CHAR_QUOTE) mode = MODE_HDR_QP;
          return 1'b0;
        end
        MODE_HDR_QP: begin
          if (c == CHAR_QUOTE) begin
            mode = MODE_HDR_INQ;
            return 1'b0;
          end
          return header_outside(c);
        end
        MODE_DAT_INQ: begin
          if (c == CHAR_QUOTE) begin
            mode = MODE_DAT_QP;
            return 1'b0;
          end
          return emit_char(c);
        end
        MODE_DAT_QP: begin
          if (c == CHAR_QUOTE) begin
            mode = MODE_DAT_INQ;
            return emit_char(c);
          end
          return data_outside(c);
        end
        default: return data_outside(c);
      endcase
    endfunction

    function void note_item(logic [7:0] c, logic eoi);
      if (tokenize_byte(c, eoi)) expected_tokens.push_back(token);
    endfunction

    function string show(result_t t);
      return $sformatf("cv=%0b ch=%02h col=%0d fd=%0b rd=%0b id=%0b drop=%0b qerr=%0b",
                       t.char_valid, t.char_out, t.column_index, t.field_done,
                       t.row_done, t.input_done, t.row_dropped, t.quote_error);
    endfunction

    function void check_token(result_t got);
      result_t want;
      if (expected_tokens.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected token: %s", show(got));
        return;
      end
      want = expected_tokens.pop_front();
      if (got.char_valid !== want.char_valid || got.char_out !== want.char_out ||
          got.column_index !== want.column_index || got.field_done !== want.field_done ||
          got.row_done !== want.row_done || got.input_done !== want.input_done ||
          got.row_dropped !== want.row_dropped || got.quote_error !== want.quote_error) begin
        failures++;
        if (failures <= 10) begin
          $display("token mismatch at %0t", $time);
          $display("  expected: %s", show(want));
          $display("  actual:   %s", show(got));
        end
      end
    endfunction

    function int unsigned pending();
      return expected_tokens.size();
    endfunction
  endclass

  // A generous bound on the length of the whole run.
  localparam int unsigned CYCLE_LIMIT = 500_000;
  // Marks an end-of-input item in the directed text.
  localparam logic [8:0]  END_ITEM = 9'h100;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [15:0] cfg_data;

  csvt_in_if  in_if ();
  csvt_out_if res_if ();

  csv_field_tokenizer_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .res_o      (res_if)
  );

  token_scoreboard sb;
  logic [8:0]      directed_text[$];
  logic [7:0]      cur_delim;
  int unsigned     items_sent;
  int unsigned     burst_left;
  int unsigned     cycles;
  int unsigned     stall_left;
  int unsigned     stall_style;

  always #5 clk = ~clk;

  // Both channels are observed at the rising edge, before the block updates.
  // A token is checked before the byte of the same edge is noted; a byte
  // never answers within the edge that takes it, so the order is safe.
  always @(posedge clk) begin
    if (rst_n) begin
      if (res_if.valid && res_if.ready)
        sb.check_token({res_if.char_valid, res_if.char_out, res_if.column_index,
                        res_if.field_done, res_if.row_done, res_if.input_done,
                        res_if.row_dropped, res_if.quote_error});
      if (in_if.valid && in_if.ready) sb.note_item(in_if.in_byte, in_if.end_of_input);
    end
  end

  // The receiver switches between always ready, light random stalls, heavy
  // random stalls and a fixed one-in-three pattern.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left  = $urandom_range(32, 200);
    end
    stall_left--;
    case (stall_style)
      0: res_if.ready = 1'b1;
      1: res_if.ready = ($urandom_range(0, 3) != 0);
      2: res_if.ready = ($urandom_range(0, 3) == 0);
      default: res_if.ready = (cycles % 3 == 0);
    endcase
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offers one item and returns at the falling edge after it is taken. The
  // sender runs in bursts; between bursts valid drops for a random gap.
  task automatic send_item(input logic [7:0] c, input logic eoi);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_if.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_if.valid        = 1'b1;
    // The byte is ignored on end of input, so it carries noise there.
    in_if.in_byte      = eoi ? 8'($urandom_range(0, 255)) : c;
    in_if.end_of_input = eoi;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    items_sent++;
  endtask

  // Holds the sender until every expected token has come, then lets the
  // pipeline empty of items that make no token.
  task automatic wait_drain();
    in_if.valid = 1'b0;
    burst_left  = 0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.load_reg(idx, data);
  endtask

  task automatic set_config(input logic [7:0] delim, input logic trim_en,
                            input logic [15:0] hdr_lines);
    wait_drain();
    write_reg(CFG_DELIMITER, {8'h00, delim});
    write_reg(CFG_TRIM, {15'h0000, trim_en});
    write_reg(CFG_HDR_SKIP, hdr_lines);
    cur_delim = delim;
  endtask

  // Mostly ordinary text characters, now and then a blank or any byte.
  function automatic logic [7:0] plain_char();
    case ($urandom_range(0, 9))
      0: return 8'($urandom_range(0, 255));
      1: return CHAR_SPACE;
      2: return 8'h30 + 8'($urandom_range(0, 9));
      default: return 8'h61 + 8'($urandom_range(0, 25));
    endcase
  endfunction

  // One field: optional leading blanks, then plain text or a quoted body
  // holding escaped quotes, delimiters and line breaks.
  task automatic send_field();
    int unsigned n;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2)) send_item($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB, 1'b0);
    if ($urandom_range(0, 2) == 0) begin
      send_item(CHAR_QUOTE, 1'b0);
      n = $urandom_range(0, 5);
      repeat (n) begin
        case ($urandom_range(0, 7))
          0: begin
            send_item(CHAR_QUOTE, 1'b0);
            send_item(CHAR_QUOTE, 1'b0);
          end
          1: send_item(cur_delim, 1'b0);
          2: send_item(CHAR_LF, 1'b0);
          3: send_item(CHAR_CR, 1'b0);
          default: send_item(plain_char(), 1'b0);
        endcase
      end
      send_item(CHAR_QUOTE, 1'b0);
      // Text after a closing quote joins the same field.
      if ($urandom_range(0, 5) == 0) send_item(plain_char(), 1'b0);
    end else begin
      repeat ($urandom_range(0, 6)) send_item(plain_char(), 1'b0);
    end
  endtask

  task automatic send_row();
    int unsigned nf;
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1)) send_item(CHAR_CR, 1'b0);
      send_item(CHAR_LF, 1'b0);
      return;
    end
    nf = $urandom_range(1, 5);
    for (int unsigned i = 0; i < nf; i++) begin
      if (i != 0) send_item(cur_delim, 1'b0);
      send_field();
    end
    if ($urandom_range(0, 9) == 0) send_item(cur_delim, 1'b0);
    if ($urandom_range(0, 2) == 0) send_item(CHAR_CR, 1'b0);
    send_item(CHAR_LF, 1'b0);
  endtask

  // A small file; the first rows serve as header lines when skipping is on.
  // Most files end cleanly, some stop mid-field, inside a quote or right
  // after a closing quote, and a few run on into the next file.
  task automatic send_file();
    repeat ($urandom_range(1, 5)) send_row();
    case ($urandom_range(0, 9))
      6: begin
        send_item(plain_char(), 1'b0);
        send_item(END_ITEM[7:0], 1'b1);
      end
      7: begin
        send_item(CHAR_QUOTE, 1'b0);
        send_item(plain_char(), 1'b0);
        send_item(END_ITEM[7:0], 1'b1);
      end
      8: begin
        send_item(CHAR_QUOTE, 1'b0);
        send_item(CHAR_QUOTE, 1'b0);
        send_item(END_ITEM[7:0], 1'b1);
      end
      9: ;
      default: send_item(END_ITEM[7:0], 1'b1);
    endcase
  endtask

  // Random text until about n more items have gone in: mostly files, some
  // raw noise, and now and then a full pause until all tokens are out.
  task automatic run_random(input int unsigned n);
    int unsigned target;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(0, 6) == 0)
        repeat ($urandom_range(5, 20))
          send_item(8'($urandom_range(0, 255)), ($urandom_range(0, 15) == 0));
      else
        send_file();
      if ($urandom_range(0, 4) == 0) wait_drain();
    end
  endtask

  initial begin
    sb          = new();
    clk         = 1'b0;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = CFG_DELIMITER;
    cfg_data    = '0;
    in_if.valid        = 1'b0;
    in_if.in_byte      = '0;
    in_if.end_of_input = 1'b0;
    res_if.ready       = 1'b0;
    cur_delim   = CHAR_COMMA;
    items_sent  = 0;
    burst_left  = 0;
    cycles      = 0;
    stall_left  = 0;
    stall_style = 0;

    // Directed text under the reset settings: an empty line, trimmed blanks,
    // a zero byte, an empty quoted field closed by a newline, an escaped
    // quote followed by text after the closing quote, a 0xFF byte, a row that
    // ends in a delimiter with CR dropped, end inside an open quote, end
    // right after a closing quote, and end in the middle of a row.
    directed_text = '{
      {1'b0, CHAR_LF}, {1'b0, CHAR_SPACE}, {1'b0, CHAR_TAB}, 9'h000,
      {1'b0, CHAR_COMMA}, {1'b0, CHAR_QUOTE}, {1'b0, CHAR_QUOTE}, {1'b0, CHAR_LF},
      {1'b0, CHAR_QUOTE}, {1'b0, "a"}, {1'b0, CHAR_QUOTE}, {1'b0, CHAR_QUOTE},
      {1'b0, CHAR_QUOTE}, {1'b0, "b"}, {1'b0, CHAR_COMMA}, 9'h0FF,
      {1'b0, CHAR_COMMA}, {1'b0, CHAR_CR}, {1'b0, CHAR_LF}, {1'b0, CHAR_QUOTE},
      END_ITEM, {1'b0, CHAR_QUOTE}, {1'b0, CHAR_QUOTE}, END_ITEM,
      {1'b0, "z"}, END_ITEM
    };

    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed_text[i]) send_item(directed_text[i][7:0], directed_text[i][8]);

    // Register phases. Parser state carries across them, so a lowered header
    // count takes effect on the next header byte.
    set_config(CHAR_COMMA, 1'b1, 16'd0);
    run_random(40);
    set_config(";", 1'b0, 16'd2);
    run_random(40);
    set_config(8'h00, 1'b1, 16'd1);
    run_random(35);

    // A wide row walks the column count far up; end of input first puts the
    // parser back into its starting state.
    set_config(8'hFF, 1'b0, 16'd0);
    send_item(END_ITEM[7:0], 1'b1);
    repeat (60) send_item(8'hFF, 1'b0);
    send_item("q", 1'b0);
    send_item(CHAR_LF, 1'b0);
    run_random(35);

    // A tab delimiter wins over trimming.
    set_config(CHAR_TAB, 1'b1, 16'd3);
    run_random(40);
    // A quote never acts as a delimiter; the largest header count keeps the
    // parser in header lines after each end of input in this phase.
    set_config(CHAR_QUOTE, 1'b0, 16'hFFFF);
    run_random(25);
    // A newline delimiter is always taken as a line end.
    set_config(CHAR_LF, 1'b1, 16'd0);
    run_random(35);
    set_config(CHAR_COMMA, 1'b0, 16'd1);
    run_random(50);

    // All items are in: wait for the last tokens, then watch for strays.
    wait_drain();
    repeat (8) @(negedge clk);

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
